// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FLBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FLBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FLBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/flbt_pkg.sv =====
package flbt_pkg;

    // request operations
    typedef enum logic [1:0] {
        MODE_LOG   = 2'd0,
        MODE_UNLOG = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    // request in flight: valid plus operation
    typedef struct packed {
        logic  valid;
        mode_t mode;
    } op_t;

    localparam int MODE_W       = 2;
    localparam int ADDR_FIELD_W = 48;
    localparam int TOP_COUNT_W  = 5;
    localparam int CARD_COUNT_W = 11;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 24;

    // address bits consumed per index pipeline stage
    localparam int BITS_PER_STAGE = 4;

    // table status seen by the top level
    typedef struct packed {
        logic                    clearing;
        logic [TOP_COUNT_W-1:0]  top_count;
        logic [CARD_COUNT_W-1:0] card_count;
    } status_t;

endpackage

// ===== hw/rtl/flbt_index.sv =====
module flbt_index #(
    parameter int TOP_ENTRIES     = 16,
    parameter int CARDS_PER_BLOCK = 64,
    parameter int CARD_BYTES_LOG2 = 8,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  flbt_pkg::op_t                       in_op,
    input  logic [flbt_pkg::ADDR_FIELD_W-1:0]   address,
    output flbt_pkg::op_t                       out_op,
    output logic [$clog2(TOP_ENTRIES)-1:0]      top,
    output logic [$clog2(CARDS_PER_BLOCK)-1:0]  card,
    output logic [CARD_BYTES_LOG2-3:0]          word
);

    localparam int AB  = (ADDRESS_BITS < flbt_pkg::ADDR_FIELD_W) ?
                         ADDRESS_BITS : flbt_pkg::ADDR_FIELD_W;
    localparam int QW  = AB - CARD_BYTES_LOG2;
    localparam int BPS = flbt_pkg::BITS_PER_STAGE;
    localparam int NS  = (QW + BPS - 1) / BPS;
    localparam int CW  = $clog2(CARDS_PER_BLOCK);
    localparam int TW  = $clog2(TOP_ENTRIES);
    localparam int WW  = CARD_BYTES_LOG2 - 2;
    localparam logic [CW:0] CPB_C = (CW + 1)'(CARDS_PER_BLOCK);
    localparam logic [TW:0] TE_C  = (TW + 1)'(TOP_ENTRIES);

    // one quotient bit: card remainder by cards per block, quotient folded modulo top entries
    function automatic logic [CW+TW-1:0] div_step(
        input logic [CW-1:0] rc,
        input logic [TW-1:0] rt,
        input logic          b
    );
        logic [CW:0] c2;
        logic [TW:0] t2;
        logic        qb;
        c2 = {rc, b};
        qb = (c2 >= CPB_C);
        if (qb)
        begin
            c2 = c2 - CPB_C;
        end
        t2 = {rt, qb};
        if (t2 >= TE_C)
        begin
            t2 = t2 - TE_C;
        end
        return {c2[CW-1:0], t2[TW-1:0]};
    endfunction

    flbt_pkg::op_t op_reg [NS];
    logic [QW-1:0] q_reg  [NS];
    logic [CW-1:0] rc_reg [NS];
    logic [TW-1:0] rt_reg [NS];
    logic [WW-1:0] wd_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        flbt_pkg::op_t prev_op;
        logic [QW-1:0] prev_q;
        logic [CW-1:0] prev_rc;
        logic [TW-1:0] prev_rt;
        logic [WW-1:0] prev_wd;
        logic [CW-1:0] rc_c;
        logic [TW-1:0] rt_c;

        if (s == 0)
        begin : g_first
            assign prev_op = in_op;
            assign prev_q  = address[AB-1:CARD_BYTES_LOG2];
            assign prev_rc = '0;
            assign prev_rt = '0;
            assign prev_wd = address[CARD_BYTES_LOG2-1:2];
        end
        else
        begin : g_next
            assign prev_op = op_reg[s-1];
            assign prev_q  = q_reg[s-1];
            assign prev_rc = rc_reg[s-1];
            assign prev_rt = rt_reg[s-1];
            assign prev_wd = wd_reg[s-1];
        end

        always_comb
        begin
            rc_c = prev_rc;
            rt_c = prev_rt;
            for (int j = 0; j < BPS; j++)
            begin
                if (s * BPS + j < QW)
                begin
                    {rc_c, rt_c} = div_step(rc_c, rt_c, prev_q[QW - 1 - (s * BPS + j)]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                op_reg[s] <= '0;
            end
            else if (adv)
            begin
                op_reg[s] <= prev_op;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[s]  <= prev_q;
                rc_reg[s] <= rc_c;
                rt_reg[s] <= rt_c;
                wd_reg[s] <= prev_wd;
            end
        end
    end

    assign out_op = op_reg[NS-1];
    assign top    = rt_reg[NS-1];
    assign card   = rc_reg[NS-1];
    assign word   = wd_reg[NS-1];

endmodule

// ===== hw/rtl/flbt_table.sv =====
module flbt_table #(
    parameter int TOP_ENTRIES     = 16,
    parameter int CARDS_PER_BLOCK = 64,
    parameter int CARD_BYTES_LOG2 = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  flbt_pkg::op_t                         req_op,
    input  logic [$clog2(TOP_ENTRIES)-1:0]        req_top,
    input  logic [$clog2(CARDS_PER_BLOCK)-1:0]    req_card,
    input  logic [CARD_BYTES_LOG2-3:0]            req_word,
    output logic                                  res_valid,
    output logic                                  res_success,
    output logic [flbt_pkg::TOP_COUNT_W-1:0]      res_top_count,
    output logic [flbt_pkg::CARD_COUNT_W-1:0]     res_card_count,
    output flbt_pkg::status_t                     status
);

    localparam int CW  = $clog2(CARDS_PER_BLOCK);
    localparam int TW  = $clog2(TOP_ENTRIES);
    localparam int WW  = CARD_BYTES_LOG2 - 2;
    localparam int WPC = 1 << WW;
    localparam int RW  = WPC + 1;
    localparam int AW  = TW + CW;
    localparam int TCW = flbt_pkg::TOP_COUNT_W;
    localparam int CCW = flbt_pkg::CARD_COUNT_W;

    // row: card present bit on top, one logged flag per word below
    logic [RW-1:0] row_mem [1 << AW];
    logic          top_mem [1 << TW];

    logic [RW-1:0]  row_rd_reg;
    logic           top_rd_reg;
    flbt_pkg::op_t  s1_op_reg;
    logic [TW-1:0]  s1_top_reg;
    logic [CW-1:0]  s1_card_reg;
    logic [WW-1:0]  s1_word_reg;

    logic           fwd_row_valid_reg;
    logic [AW-1:0]  fwd_addr_reg;
    logic [RW-1:0]  fwd_row_reg;
    logic           fwd_top_valid_reg;
    logic [TW-1:0]  fwd_top_reg;

    logic           clearing_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [TCW-1:0] top_count_reg;
    logic [CCW-1:0] card_count_reg;
    logic [TCW-1:0] top_count_next;
    logic [CCW-1:0] card_count_next;

    logic           out_valid_reg;
    logic           out_success_reg;
    logic [TCW-1:0] out_top_reg;
    logic [CCW-1:0] out_card_reg;

    logic [AW-1:0]  s1_addr;
    logic [RW-1:0]  row_cur;
    logic [RW-1:0]  row_new;
    logic           top_pres;
    logic           card_pres;
    logic           flag;
    logic           ok;
    logic           row_wr;
    logic           top_wr;
    logic           row_we;
    logic [AW-1:0]  row_wa;
    logic [RW-1:0]  row_wd;
    logic           top_we;
    logic [TW-1:0]  top_wa;
    logic           top_wd;

    assign s1_addr   = {s1_top_reg, s1_card_reg};
    // rmw forwarding: the item ahead wrote at the same edge this one read
    assign row_cur   = (fwd_row_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_row_reg
                                                                        : row_rd_reg;
    assign top_pres  = top_rd_reg || (fwd_top_valid_reg && (fwd_top_reg == s1_top_reg));
    assign card_pres = row_cur[WPC];
    assign flag      = row_cur[s1_word_reg];

    always_comb
    begin
        row_new         = row_cur;
        ok              = 1'b0;
        row_wr          = 1'b0;
        top_wr          = 1'b0;
        top_count_next  = top_count_reg;
        card_count_next = card_count_reg;
        if (s1_op_reg.valid)
        begin
            unique case (s1_op_reg.mode)
                flbt_pkg::MODE_LOG:
                begin
                    row_new[WPC]         = 1'b1;
                    row_new[s1_word_reg] = 1'b1;
                    ok                   = !flag;
                    row_wr               = 1'b1;
                    top_wr               = 1'b1;
                    top_count_next       = top_count_reg + TCW'(!top_pres);
                    card_count_next      = card_count_reg + CCW'(!card_pres);
                end
                flbt_pkg::MODE_UNLOG:
                begin
                    ok     = top_pres && card_pres && flag;
                    row_wr = 1'b1;
                    if (ok)
                    begin
                        row_new[s1_word_reg] = 1'b0;
                    end
                end
                flbt_pkg::MODE_QUERY:
                begin
                    ok = top_pres && card_pres && flag;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    // clearing pass owns the write ports until it is done
    always_comb
    begin
        if (clearing_reg)
        begin
            row_we = 1'b1;
            row_wa = clr_cnt_reg;
            row_wd = '0;
            top_we = 1'b1;
            top_wa = clr_cnt_reg[TW-1:0];
            top_wd = 1'b0;
        end
        else
        begin
            row_we = adv && row_wr;
            row_wa = s1_addr;
            row_wd = row_new;
            top_we = adv && top_wr;
            top_wa = s1_top_reg;
            top_wd = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        if (adv)
        begin
            row_rd_reg <= row_mem[{req_top, req_card}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_wa] <= top_wd;
        end
        if (adv)
        begin
            top_rd_reg <= top_mem[req_top];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (&clr_cnt_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg         <= '0;
            fwd_row_valid_reg <= 1'b0;
            fwd_top_valid_reg <= 1'b0;
            top_count_reg     <= '0;
            card_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else if (adv)
        begin
            s1_op_reg         <= req_op;
            fwd_row_valid_reg <= row_wr;
            fwd_top_valid_reg <= top_wr;
            top_count_reg     <= top_count_next;
            card_count_reg    <= card_count_next;
            out_valid_reg     <= s1_op_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_top_reg      <= req_top;
            s1_card_reg     <= req_card;
            s1_word_reg     <= req_word;
            fwd_addr_reg    <= s1_addr;
            fwd_row_reg     <= row_new;
            fwd_top_reg     <= s1_top_reg;
            out_success_reg <= ok;
            out_top_reg     <= top_count_next;
            out_card_reg    <= card_count_next;
        end
    end

    assign res_valid         = out_valid_reg;
    assign res_success       = out_success_reg;
    assign res_top_count     = out_top_reg;
    assign res_card_count    = out_card_reg;
    assign status.clearing   = clearing_reg;
    assign status.top_count  = top_count_reg;
    assign status.card_count = card_count_reg;

endmodule

// ===== hw/rtl/field_log_bit_table.sv =====
// pipeline: a request goes through the index stages, the table read stage, then the
// result register; throughput: one request per cycle while no result waits at the
// output, set by the single row-memory rmw port
// reset: a clearing pass writes 2^(clog2(TOP_ENTRIES) + clog2(CARDS_PER_BLOCK))
// rows, 1024 with the defaults, with s_tready low; counts restart at zero
`include "assert_macros.svh"

module field_log_bit_table #(
    parameter int TOP_ENTRIES     = 16,
    parameter int CARDS_PER_BLOCK = 64,
    parameter int CARD_BYTES_LOG2 = 8,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode [1:0], word_address [49:2], zero pad [55:50]
    input  logic [flbt_pkg::IN_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // success [0], top_stripes_used [5:1], card_stripes_used [16:6], zero pad [23:17]
    output logic [flbt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int CW = $clog2(CARDS_PER_BLOCK);
    localparam int TW = $clog2(TOP_ENTRIES);
    localparam int WW = CARD_BYTES_LOG2 - 2;
    localparam int MW = flbt_pkg::MODE_W;
    localparam int FW = flbt_pkg::ADDR_FIELD_W;
    localparam int PW = flbt_pkg::OUT_DATA_W - 1 - flbt_pkg::TOP_COUNT_W
                        - flbt_pkg::CARD_COUNT_W;

    // whole pipeline moves together; it stalls only while a result waits at the output
    logic                               adv;
    flbt_pkg::op_t                      in_op;
    flbt_pkg::op_t                      idx_op;
    logic [TW-1:0]                      idx_top;
    logic [CW-1:0]                      idx_card;
    logic [WW-1:0]                      idx_word;
    logic                               res_valid;
    logic                               res_success;
    logic [flbt_pkg::TOP_COUNT_W-1:0]   res_top_count;
    logic [flbt_pkg::CARD_COUNT_W-1:0]  res_card_count;
    flbt_pkg::status_t                  status;

    assign adv      = !res_valid || m_tready;
    // no requests until the rows are cleared
    assign s_tready = adv && !status.clearing;

    assign in_op.valid = s_tvalid && s_tready;
    assign in_op.mode  = flbt_pkg::mode_t'(s_tdata[MW-1:0]);

    // address split: top index and card by serial division, word by slicing
    flbt_index #(
        .TOP_ENTRIES     (TOP_ENTRIES),
        .CARDS_PER_BLOCK (CARDS_PER_BLOCK),
        .CARD_BYTES_LOG2 (CARD_BYTES_LOG2),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_op   (in_op),
        .address (s_tdata[MW+FW-1:MW]),
        .out_op  (idx_op),
        .top     (idx_top),
        .card    (idx_card),
        .word    (idx_word)
    );

    // stripe and flag memories with read-modify-write and forwarding
    flbt_table #(
        .TOP_ENTRIES     (TOP_ENTRIES),
        .CARDS_PER_BLOCK (CARDS_PER_BLOCK),
        .CARD_BYTES_LOG2 (CARD_BYTES_LOG2)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .req_op         (idx_op),
        .req_top        (idx_top),
        .req_card       (idx_card),
        .req_word       (idx_word),
        .res_valid      (res_valid),
        .res_success    (res_success),
        .res_top_count  (res_top_count),
        .res_card_count (res_card_count),
        .status         (status)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {{PW{1'b0}}, res_card_count, res_top_count, res_success};

    `FLBT_ASSERT_IMPLY(a_no_req_clearing, clk, rst_n, status.clearing, !s_tready, "request taken while clearing")
    `FLBT_ASSERT_IMPLY(a_no_res_clearing, clk, rst_n, status.clearing, !m_tvalid, "result shown while clearing")
    `FLBT_ASSERT_IMPLY(a_top_with_card, clk, rst_n, status.top_count != $past(status.top_count), status.card_count != $past(status.card_count), "top stripe allocated without card stripe")
    `FLBT_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !adv, $stable(status.card_count), "card count moved during stall")

endmodule
